// ===== sv/kpc_pkg.sv =====
package kpc_pkg;

  // Register map, word index of each configuration register
  typedef enum logic [2:0] {
    REG_SAMPLE_GAP  = 3'd0,
    REG_SHORT_TICKS = 3'd1,
    REG_LONG_TICKS  = 3'd2,
    REG_MSG_GAP     = 3'd3,
    REG_MSG_LIMIT   = 3'd4
  } reg_idx_t;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GAP_W    = 10;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned MSG_W    = 5;

  localparam logic [GAP_W-1:0]  SAMPLE_GAP_RST  = 10'd10;
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd200;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd3000;
  localparam logic [TICK_W-1:0] MSG_GAP_RST     = 16'd1000;
  localparam logic [MSG_W-1:0]  MSG_LIMIT_RST   = 5'd15;
  localparam logic [TICK_W-1:0] TICK_MAX        = '1;

  // Press tracking: idle, or long press flagged and waiting for release
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WAIT = 2'b10
  } phase_t;

  // One result request
  typedef struct packed {
    logic             sampled;
    logic             short_press;
    logic             long_press;
    logic             send_pairing_msg;
    logic             pairing_on;
    logic [MSG_W-1:0] msgs_sent;
  } res_t;

endpackage

// ===== sv/key_press_classifier_pairing_timer.sv =====
// Pairing-key press classifier with pairing-message timer.
// Input channel (in_valid / in_stall / in_key_level): one request per time
// tick carrying the raw active-low key level. Result channel (out_valid /
// out_stall / out_*): exactly one result request per input request, in order.
// Configuration goes through the APB port (psel ... pready); registers sit at
// byte addresses 0, 4, 8, 12, 16 and must only be written while idle.
// An accepted input's result is written to the result register, or to the
// skid register when the result register is held. Throughput: one request
// per cycle while in_stall is low. All per-tick work is a handful of counter
// increments and compares done in the accept cycle, written into a result
// register backed by a one-entry skid register. When the receiver stalls,
// the result register holds; one more input is taken into the skid register,
// after which in_stall rises until the result register drains.
// Reset (rst_n low, synchronous): all counters, the press phase and pairing
// mode clear, configuration returns to its defaults, both result slots empty.
module key_press_classifier_pairing_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_key_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_sampled,
  output logic                         out_short_press,
  output logic                         out_long_press,
  output logic                         out_send_pairing_msg,
  output logic                         out_pairing_on,
  output logic [kpc_pkg::MSG_W-1:0]    out_msgs_sent,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [kpc_pkg::DATA_W-1:0]   pwdata,
  output logic [kpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import kpc_pkg::*;

  // Configuration registers
  logic [GAP_W-1:0]  sample_gap_r;
  logic [TICK_W-1:0] short_ticks_r;
  logic [TICK_W-1:0] long_ticks_r;
  logic [TICK_W-1:0] msg_gap_r;
  logic [MSG_W-1:0]  msg_limit_r;

  // Tick state
  logic [GAP_W-1:0]  smp_cnt_r,  smp_cnt_nxt;
  logic [TICK_W-1:0] hold_r,     hold_nxt;
  logic              key_down_r, key_down_nxt;
  phase_t            phase_r,    phase_nxt;
  logic [TICK_W-1:0] gap_r,      gap_nxt;
  logic [MSG_W-1:0]  msg_cnt_r,  msg_cnt_nxt;
  logic              pairing_r,  pairing_nxt;

  // Result register and skid register
  res_t res_r, skid_r, res_new;
  logic out_vld_r, skid_vld_r;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              in_acc;
  logic              out_take;
  logic [GAP_W-1:0]  smp_inc;
  logic [TICK_W-1:0] hold_inc;
  logic [TICK_W-1:0] gap_inc;
  logic              smp_hit;
  logic              pressed;
  logic              short_hit;
  logic              long_hit;
  logic              send_hit;
  logic [MSG_W-1:0]  msg_inc;

  // APB register port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_gap_r  <= SAMPLE_GAP_RST;
      short_ticks_r <= SHORT_TICKS_RST;
      long_ticks_r  <= LONG_TICKS_RST;
      msg_gap_r     <= MSG_GAP_RST;
      msg_limit_r   <= MSG_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SAMPLE_GAP:  sample_gap_r  <= pwdata[GAP_W-1:0];
        REG_SHORT_TICKS: short_ticks_r <= pwdata[TICK_W-1:0];
        REG_LONG_TICKS:  long_ticks_r  <= pwdata[TICK_W-1:0];
        REG_MSG_GAP:     msg_gap_r     <= pwdata[TICK_W-1:0];
        REG_MSG_LIMIT:   msg_limit_r   <= pwdata[MSG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_SAMPLE_GAP:  prdata = DATA_W'(sample_gap_r);
      REG_SHORT_TICKS: prdata = DATA_W'(short_ticks_r);
      REG_LONG_TICKS:  prdata = DATA_W'(long_ticks_r);
      REG_MSG_GAP:     prdata = DATA_W'(msg_gap_r);
      REG_MSG_LIMIT:   prdata = DATA_W'(msg_limit_r);
      default:         prdata = '0;
    endcase
  end

  // Handshakes
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid & ~skid_vld_r;
  assign out_take  = out_vld_r & ~out_stall;

  // Free-running counters advance every tick
  assign smp_inc  = smp_cnt_r + GAP_W'(1);
  assign hold_inc = (hold_r == TICK_MAX) ? TICK_MAX : hold_r + TICK_W'(1);
  assign gap_inc  = (gap_r == TICK_MAX) ? TICK_MAX : gap_r + TICK_W'(1);
  assign smp_hit  = (smp_inc >= sample_gap_r);
  assign pressed  = ~in_key_level;
  assign msg_inc  = msg_cnt_r + MSG_W'(1);

  // Per-tick press classification and message timing
  always_comb begin
    smp_cnt_nxt  = smp_inc;
    hold_nxt     = hold_inc;
    gap_nxt      = gap_inc;
    key_down_nxt = key_down_r;
    phase_nxt    = phase_r;
    msg_cnt_nxt  = msg_cnt_r;
    pairing_nxt  = pairing_r;
    short_hit    = 1'b0;
    long_hit     = 1'b0;
    send_hit     = 1'b0;
    if (smp_hit) begin
      smp_cnt_nxt  = '0;
      key_down_nxt = pressed;
      if (pressed) begin
        if (!key_down_r) begin
          hold_nxt = '0;
        end else if (phase_r == PH_IDLE && hold_inc > long_ticks_r) begin
          long_hit  = 1'b1;
          phase_nxt = PH_WAIT;
        end
      end else begin
        if (!key_down_r || phase_r != PH_IDLE) begin
          phase_nxt = PH_IDLE;
        end else if (hold_inc > short_ticks_r) begin
          short_hit = 1'b1;
        end
        hold_nxt = '0;
      end
      // short press opens a fresh pairing session
      if (short_hit) begin
        pairing_nxt = 1'b1;
      end
      if ((short_hit || pairing_r) && gap_inc >= msg_gap_r) begin
        gap_nxt  = '0;
        send_hit = 1'b1;
        msg_cnt_nxt = short_hit ? MSG_W'(1) : msg_inc;
        if (msg_cnt_nxt >= msg_limit_r) begin
          msg_cnt_nxt = '0;
          pairing_nxt = 1'b0;
        end
      end else if (short_hit) begin
        msg_cnt_nxt = '0;
      end
    end
  end

  always_comb begin
    res_new.sampled          = smp_hit;
    res_new.short_press      = short_hit;
    res_new.long_press       = long_hit;
    res_new.send_pairing_msg = send_hit;
    res_new.pairing_on       = pairing_nxt;
    res_new.msgs_sent        = msg_cnt_nxt;
  end

  // State commits on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_cnt_r  <= '0;
      hold_r     <= '0;
      key_down_r <= 1'b0;
      phase_r    <= PH_IDLE;
      gap_r      <= '0;
      msg_cnt_r  <= '0;
      pairing_r  <= 1'b0;
    end else if (in_acc) begin
      smp_cnt_r  <= smp_cnt_nxt;
      hold_r     <= hold_nxt;
      key_down_r <= key_down_nxt;
      phase_r    <= phase_nxt;
      gap_r      <= gap_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
      pairing_r  <= pairing_nxt;
    end
  end

  // Result register with skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        res_r <= skid_r;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        res_r <= res_new;
      end else begin
        skid_r <= res_new;
      end
    end
  end

  assign out_valid            = out_vld_r;
  assign out_sampled          = res_r.sampled;
  assign out_short_press      = res_r.short_press;
  assign out_long_press       = res_r.long_press;
  assign out_send_pairing_msg = res_r.send_pairing_msg;
  assign out_pairing_on       = res_r.pairing_on;
  assign out_msgs_sent        = res_r.msgs_sent;

  // Skid slot only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid slot occupied with empty result register");

  // Message count is only nonzero inside a pairing session
  a_cnt_in_session: assert property (@(posedge clk) disable iff (!rst_n)
    !pairing_r |-> (msg_cnt_r == '0))
    else $error("message count nonzero outside pairing");

  // Waiting for release implies the key was seen down
  a_wait_key_down: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> key_down_r)
    else $error("waiting for release with key up");

  // Pulses only on sample instants, and never both press kinds at once
  a_pulse_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.short_press || res_r.long_press || res_r.send_pairing_msg))
      |-> res_r.sampled)
    else $error("pulse on a non-sample tick");

  a_one_press_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.short_press && res_r.long_press))
    else $error("short and long press in one result");

endmodule

// ===== sim/key_press_classifier_pairing_timer_tb.sv =====
module key_press_classifier_pairing_timer_tb;
  import kpc_pkg::*;

  localparam int unsigned RUN_LIMIT = 8 * 600_000;
  localparam int unsigned MAX_PRINTS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_key_level = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_sampled;
  logic out_short_press;
  logic out_long_press;
  logic out_send_pairing_msg;
  logic out_pairing_on;
  logic [MSG_W-1:0] out_msgs_sent;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  key_press_classifier_pairing_timer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key_level(in_key_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sampled(out_sampled),
    .out_short_press(out_short_press),
    .out_long_press(out_long_press),
    .out_send_pairing_msg(out_send_pairing_msg),
    .out_pairing_on(out_pairing_on),
    .out_msgs_sent(out_msgs_sent),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Traffic shaping
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned mismatch_cnt = 0;

  // Shadow configuration
  logic [GAP_W-1:0] cfg_gap = SAMPLE_GAP_RST;
  logic [TICK_W-1:0] cfg_short = SHORT_TICKS_RST;
  logic [TICK_W-1:0] cfg_long = LONG_TICKS_RST;
  logic [TICK_W-1:0] cfg_msg_gap = MSG_GAP_RST;
  logic [MSG_W-1:0] cfg_limit = MSG_LIMIT_RST;

  // Shadow classifier state
  logic [GAP_W-1:0] smp_cnt = '0;
  logic [TICK_W-1:0] hold_t = '0;
  logic key_down = 1'b0;
  phase_t phase = PH_IDLE;
  logic [TICK_W-1:0] since_msg = '0;
  logic [MSG_W-1:0] n_msgs = '0;
  logic pairing = 1'b0;

  res_t tick_results_q[$];

  initial begin
    forever begin
      #4 clk = ~clk;
    end
  end

  // Classify one tick and advance the shadow state
  function automatic res_t classify_tick(input logic key);
    res_t r;
    logic pressed;
    r = '0;
    pressed = ~key;
    smp_cnt = smp_cnt + 1'b1;
    if (hold_t != TICK_MAX) hold_t = hold_t + 1'b1;
    if (since_msg != TICK_MAX) since_msg = since_msg + 1'b1;
    if (smp_cnt >= cfg_gap) begin
      smp_cnt = '0;
      r.sampled = 1'b1;
      if (pressed) begin
        if (!key_down) begin
          hold_t = '0;
        end else if (phase == PH_IDLE && hold_t > cfg_long) begin
          r.long_press = 1'b1;
          phase = PH_WAIT;
        end
      end else begin
        // release: a flagged long press swallows the short press
        if (!key_down || phase != PH_IDLE) begin
          phase = PH_IDLE;
        end else if (hold_t > cfg_short) begin
          r.short_press = 1'b1;
        end
        hold_t = '0;
      end
      key_down = pressed;
      if (r.short_press) begin
        pairing = 1'b1;
        n_msgs = '0;
      end
      if (pairing && since_msg >= cfg_msg_gap) begin
        since_msg = '0;
        r.send_pairing_msg = 1'b1;
        n_msgs = n_msgs + 1'b1;
        if (n_msgs >= cfg_limit) begin
          n_msgs = '0;
          pairing = 1'b0;
        end
      end
    end
    r.pairing_on = pairing;
    r.msgs_sent = n_msgs;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    // keep the log bounded if the block goes badly wrong
    if (mismatch_cnt < MAX_PRINTS)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one tick request; returns at the edge that accepts it
  task automatic send_tick(input logic key);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_key_level = key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tick_results_q.push_back(classify_tick(key));
  endtask

  // Stop offering and wait for every pending result
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SAMPLE_GAP:  cfg_gap = val[GAP_W-1:0];
      REG_SHORT_TICKS: cfg_short = val[TICK_W-1:0];
      REG_LONG_TICKS:  cfg_long = val[TICK_W-1:0];
      REG_MSG_GAP:     cfg_msg_gap = val[TICK_W-1:0];
      REG_MSG_LIMIT:   cfg_limit = val[MSG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_cfg(input int unsigned gap, input int unsigned short_t,
                         input int unsigned long_t, input int unsigned mgap,
                         input int unsigned lim);
    write_reg(REG_SAMPLE_GAP, gap);
    write_reg(REG_SHORT_TICKS, short_t);
    write_reg(REG_LONG_TICKS, long_t);
    write_reg(REG_MSG_GAP, mgap);
    write_reg(REG_MSG_LIMIT, lim);
  endtask

  // Defaults: sampling every tenth tick, both key levels
  task automatic test_reset_defaults();
    int i;
    for (i = 0; i < 11; i++) send_tick(i[0]);
  endtask

  // Zero sample gap, zero message gap and zero message limit
  task automatic test_zero_gaps();
    settle();
    set_cfg(0, 0, 2, 0, 0);
    // long press after three held ticks, release without short press
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    // short press, one message, pairing ends at once
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Limit lowered while pairing: next message ends pairing
  task automatic test_limit_lowered();
    settle();
    set_cfg(0, 0, 40, 3, 31);
    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    settle();
    write_reg(REG_MSG_LIMIT, 1);
    repeat (5) send_tick(1'b1);
  endtask

  // Press thresholds at or near full scale: neither press kind fires
  task automatic test_hold_saturation();
    settle();
    set_cfg(0, 65535, 65535, 65535, 31);
    repeat (24) send_tick(1'b0);
    repeat (4) send_tick(1'b1);
    settle();
    set_cfg(2, 65534, 65535, 4, 1);
    repeat (24) send_tick(1'b0);
    repeat (8) send_tick(1'b1);
  endtask

  // Receiver holds off long enough that the block stalls its input
  task automatic test_stall_backpressure();
    int i;
    settle();
    set_cfg(0, 2, 6, 1, 3);
    send_tick(1'b1);
    hold_off = 40;
    for (i = 0; i < 30; i++) send_tick(i % 10 > 6);
  endtask

  // Press/release sequences with random hold times under each traffic mix
  task automatic test_random_traffic();
    int unsigned src_mix[4] = '{0, 61, 0, 33};
    int unsigned sink_mix[4] = '{0, 0, 61, 33};
    int unsigned sent, span, hold_len, rel_len, lo_short;
    int p, s, k;
    for (p = 0; p < 4; p++) begin
      for (s = 0; s < 2; s++) begin
        settle();
        src_idle_pct = src_mix[p];
        sink_stall_pct = sink_mix[p];
        lo_short = $urandom_range(0, 6);
        set_cfg($urandom_range(0, 3), lo_short,
                ($urandom_range(99) < 20) ? $urandom_range(0, 4)
                                          : lo_short + $urandom_range(0, 12),
                $urandom_range(0, 8),
                ($urandom_range(1) != 0) ? $urandom_range(0, 31) : $urandom_range(1, 4));
        sent = 0;
        while (sent < 30) begin
          span = (int'(cfg_long) + 4) * (int'(cfg_gap) + 1);
          if ($urandom_range(99) < 15) begin
            // noise: random levels
            hold_len = $urandom_range(1, 8);
            for (k = 0; k < hold_len; k++) send_tick(1'($urandom_range(1)));
            sent += hold_len;
          end else begin
            hold_len = $urandom_range(1, span);
            rel_len = $urandom_range(1, 2 * (int'(cfg_gap) + 1) + int'(cfg_msg_gap) + 2);
            repeat (hold_len) send_tick(1'b0);
            repeat (rel_len) send_tick(1'b1);
            sent += hold_len + rel_len;
          end
        end
      end
    end
  endtask

  // Receiver: random stall, or a counted hold-off stretch
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off != 0) begin
        out_stall = 1'b1;
        hold_off--;
      end else begin
        out_stall = ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Result check against the oldest pending tick result
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        flag_mismatch("result with no request pending", 1, 0);
      end else begin
        want = tick_results_q.pop_front();
        if (out_sampled !== want.sampled)
          flag_mismatch("sampled", int'(out_sampled), int'(want.sampled));
        if (out_short_press !== want.short_press)
          flag_mismatch("short_press", int'(out_short_press), int'(want.short_press));
        if (out_long_press !== want.long_press)
          flag_mismatch("long_press", int'(out_long_press), int'(want.long_press));
        if (out_send_pairing_msg !== want.send_pairing_msg)
          flag_mismatch("send_pairing_msg", int'(out_send_pairing_msg),
                        int'(want.send_pairing_msg));
        if (out_pairing_on !== want.pairing_on)
          flag_mismatch("pairing_on", int'(out_pairing_on), int'(want.pairing_on));
        if (out_msgs_sent !== want.msgs_sent)
          flag_mismatch("msgs_sent", int'(out_msgs_sent), int'(want.msgs_sent));
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_zero_gaps();
    test_limit_lowered();
    test_hold_saturation();
    test_stall_backpressure();
    test_random_traffic();
    settle();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && tick_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
